>>> src/uv_sphere_vertex_generator_assert.svh
// Assertion macros for the UV sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define UVS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define UVS_ASSERT(label, prop, msg)
`define UVS_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> src/uvs_pkg.sv
// Shared types, constants and helper functions for the UV sphere vertex generator
package uvs_pkg;

    localparam int MAX_RINGS     = 255;
    localparam int MAX_SLICES    = 255;
    localparam int CORDIC_STAGES = 16;
    localparam int DIV_STEPS     = 40;
    localparam int QW            = 33;
    localparam int CW            = 33;

    localparam logic [7:0] RING_LIM  = 8'(MAX_RINGS);
    localparam logic [7:0] SLICE_LIM = 8'(MAX_SLICES);

    localparam logic [31:0]          PI_Q30      = 32'd3373259426;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

    localparam logic [1:0] REG_STACK_COUNT   = 2'd0;
    localparam logic [1:0] REG_SECTOR_COUNT  = 2'd1;
    localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

    localparam logic [7:0]  RST_STACK_COUNT   = 8'd16;
    localparam logic [7:0]  RST_SECTOR_COUNT  = 8'd32;
    localparam logic [15:0] RST_SPHERE_RADIUS = 16'd256;

    typedef struct packed {
        logic [7:0]    rem;
        logic [7:0]    dvd;
        logic [QW-1:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
    } rot_t;

    typedef struct packed {
        logic [15:0] vidx;
        logic [15:0] lidx;
        logic        quad;
        logic        beyond;
        logic        ring_ge;
        logic        slice_ge;
    } side_t;

    typedef struct packed {
        logic [16:0] tu;
        logic [16:0] tv;
    } tex_t;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } trig_t;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] a;
        case (i)
            0:  a = 33'sh3243F6A8;
            1:  a = 33'sh1DAC6705;
            2:  a = 33'sh0FADBAFC;
            3:  a = 33'sh07F56EA6;
            4:  a = 33'sh03FEAB76;
            5:  a = 33'sh01FFD55B;
            6:  a = 33'sh00FFFAAA;
            7:  a = 33'sh007FFF55;
            8:  a = 33'sh003FFFEA;
            9:  a = 33'sh001FFFFD;
            10: a = 33'sh000FFFFF;
            11: a = 33'sh0007FFFF;
            12: a = 33'sh0003FFFF;
            13: a = 33'sh0001FFFF;
            14: a = 33'sh0000FFFF;
            15: a = 33'sh00007FFF;
            16: a = 33'sh00003FFF;
            17: a = 33'sh00001FFF;
            18: a = 33'sh00000FFF;
            19: a = 33'sh000007FF;
            20: a = 33'sh000003FF;
            21: a = 33'sh000001FF;
            22: a = 33'sh000000FF;
            23: a = 33'sh0000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] clamp_count(input logic [7:0] v, input logic [7:0] mx);
        if (v == 8'd0) begin
            return 8'd1;
        end else if (v > mx) begin
            return mx;
        end
        return v;
    endfunction

    function automatic logic signed [15:0] sat_q14(input logic signed [19:0] v);
        if (v > 20'sd16384) begin
            return ONE_Q14;
        end else if (v < -20'sd16384) begin
            return -ONE_Q14;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] round_q30(input logic signed [CW-1:0] v);
        logic signed [CW:0] s;
        s = {v[CW-1], v} + 34'sd32768;
        return sat_q14({{2{s[CW]}}, s[CW:16]});
    endfunction

    function automatic trig_t fold_quad(input rot_t r);
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] sy;
        trig_t t;
        case (r.quad)
            2'd0: begin
                cx = r.x;
                sy = r.y;
            end
            2'd1: begin
                cx = -r.y;
                sy = r.x;
            end
            2'd2: begin
                cx = -r.x;
                sy = -r.y;
            end
            default: begin
                cx = r.y;
                sy = -r.x;
            end
        endcase
        t.c = round_q30(cx);
        t.s = round_q30(sy);
        return t;
    endfunction

endpackage

>>> src/uvs_div_cell.sv
// One restoring-division cell: one quotient bit per cell
module uvs_div_cell
    import uvs_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  logic [7:0] divisor,
    input  div_t       div_i,
    output div_t       div_o
);

    div_t       div_reg;
    div_t       div_next;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;

    always_comb begin
        trial         = {div_i.rem, div_i.dvd[7]};
        diff          = trial - {1'b0, divisor};
        ge            = trial >= {1'b0, divisor};
        div_next.rem  = ge ? diff[7:0] : trial[7:0];
        div_next.dvd  = {div_i.dvd[6:0], 1'b0};
        div_next.quo  = {div_i.quo[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
        end
    end

    assign div_o = div_reg;

endmodule

>>> src/uvs_cordic_cell.sv
// One CORDIC rotation cell: one micro-rotation per cell
module uvs_cordic_cell
    import uvs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [4:0]           shamt,
    input  logic signed [CW-1:0] angle,
    input  rot_t                 rot_i,
    output rot_t                 rot_o
);

    rot_t                 rot_reg;
    rot_t                 rot_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb begin
        dx            = rot_i.y >>> shamt;
        dy            = rot_i.x >>> shamt;
        rot_next.quad = rot_i.quad;
        if (!rot_i.z[CW-1]) begin
            rot_next.x = rot_i.x - dx;
            rot_next.y = rot_i.y + dy;
            rot_next.z = rot_i.z - angle;
        end else begin
            rot_next.x = rot_i.x + dx;
            rot_next.y = rot_i.y - dy;
            rot_next.z = rot_i.z + angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign rot_o = rot_reg;

endmodule

>>> src/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator
//
// Input channel s_*: one grid point (s_ring, s_slice) per beat, valid/ready.
// Result channel m_*: one vertex per beat: position Q8.8, unit normal Q1.14,
// texture u/v Q1.16, flat indices and the quad and off-grid flags.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 stack
// count, 1 sector count, 2 radius); write only while no beat is in flight.
// Throughput is one point per cycle while the receiver does not stall. The
// pipeline is two 40-cell divider chains, one per angle, one angle-scaling
// stage, two 16-cell CORDIC chains, then fold, normal and position stages.
// Reset empties the pipeline and loads the default grid (16 x 32, radius 1).
// When the receiver stalls the whole pipeline holds and s_ready drops; it
// advances again in the cycle m_ready rises.
`include "uv_sphere_vertex_generator_assert.svh"
module uv_sphere_vertex_generator
    import uvs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_ring,
    input  logic [7:0]         s_slice,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_pos_x,
    output logic signed [16:0] m_pos_y,
    output logic signed [16:0] m_pos_z,
    output logic signed [15:0] m_norm_x,
    output logic signed [15:0] m_norm_y,
    output logic signed [15:0] m_norm_z,
    output logic [16:0]        m_tex_u,
    output logic [16:0]        m_tex_v,
    output logic [15:0]        m_vertex_index,
    output logic [15:0]        m_lower_index,
    output logic               m_quad_valid,
    output logic               m_beyond_grid
);

    localparam int S_ANG  = DIV_STEPS;
    localparam int S_FOLD = S_ANG + CORDIC_STAGES + 1;
    localparam int S_NRM  = S_FOLD + 1;
    localparam int S_OUT  = S_NRM + 1;
    localparam int N_STG  = S_OUT + 1;
    localparam int N_TEX  = N_STG - S_ANG;

    logic [7:0]  stack_count_reg;
    logic [7:0]  sector_count_reg;
    logic [15:0] sphere_radius_reg;
    logic [7:0]  st;
    logic [7:0]  se;
    logic        adv;

    logic [N_STG-1:0] vld_reg;
    side_t            side_reg [N_STG];
    side_t            side_next;
    tex_t             tex_reg  [N_TEX];
    tex_t             tex_next;

    div_t phi_div [DIV_STEPS+1];
    div_t th_div  [DIV_STEPS+1];
    rot_t phi_rot [CORDIC_STAGES+1];
    rot_t th_rot  [CORDIC_STAGES+1];
    rot_t phi_rot_reg;
    rot_t th_rot_reg;
    rot_t phi_rot_next;
    rot_t th_rot_next;

    logic [31:0] aphi;
    logic [31:0] ath;
    logic [61:0] phi_prod;
    logic [61:0] th_prod;
    logic [8:0]  sep1;
    logic [17:0] vfull;
    logic [17:0] lfull;

    trig_t phi_trig_reg;
    trig_t th_trig_reg;
    trig_t phi_trig_next;
    trig_t th_trig_next;

    logic signed [31:0] nx_prod;
    logic signed [31:0] nz_prod;
    logic signed [32:0] nx_sum;
    logic signed [32:0] nz_sum;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic signed [15:0] nx_next;
    logic signed [15:0] nz_next;

    logic signed [16:0] rad_s;
    logic signed [32:0] px_prod;
    logic signed [32:0] py_prod;
    logic signed [32:0] pz_prod;
    logic signed [33:0] px_sum;
    logic signed [33:0] py_sum;
    logic signed [33:0] pz_sum;
    logic signed [16:0] pos_x_reg;
    logic signed [16:0] pos_y_reg;
    logic signed [16:0] pos_z_reg;
    logic signed [15:0] onx_reg;
    logic signed [15:0] ony_reg;
    logic signed [15:0] onz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg   <= RST_STACK_COUNT;
            sector_count_reg  <= RST_SECTOR_COUNT;
            sphere_radius_reg <= RST_SPHERE_RADIUS;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STACK_COUNT:   stack_count_reg   <= cfg_wdata[7:0];
                REG_SECTOR_COUNT:  sector_count_reg  <= cfg_wdata[7:0];
                REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign st      = clamp_count(stack_count_reg, RING_LIM);
    assign se      = clamp_count(sector_count_reg, SLICE_LIM);
    assign adv     = !vld_reg[S_OUT] || m_ready;
    assign s_ready = adv;

    always_comb begin
        sep1               = {1'b0, se} + 9'd1;
        vfull              = 18'(s_ring) * 18'(sep1) + 18'(s_slice);
        lfull              = vfull + 18'(sep1);
        side_next.vidx     = vfull[15:0];
        side_next.lidx     = lfull[15:0];
        side_next.quad     = (s_ring < st) && (s_slice < se);
        side_next.beyond   = (s_ring > st) || (s_slice > se);
        side_next.ring_ge  = s_ring >= st;
        side_next.slice_ge = s_slice >= se;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N_STG-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < N_STG; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign phi_div[0] = '{rem: 8'd0, dvd: s_ring,  quo: '0};
    assign th_div[0]  = '{rem: 8'd0, dvd: s_slice, quo: '0};

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        uvs_div_cell u_phi_div (
            .aclk    (aclk),
            .en      (adv),
            .divisor (st),
            .div_i   (phi_div[k]),
            .div_o   (phi_div[k+1])
        );
        uvs_div_cell u_th_div (
            .aclk    (aclk),
            .en      (adv),
            .divisor (se),
            .div_i   (th_div[k]),
            .div_o   (th_div[k+1])
        );
    end

    always_comb begin
        aphi              = phi_div[DIV_STEPS].quo[32:1];
        ath               = th_div[DIV_STEPS].quo[31:0];
        phi_prod          = 62'(aphi[29:0]) * 62'(PI_Q30);
        th_prod           = 62'(ath[29:0]) * 62'(PI_Q30);
        phi_rot_next.x    = CORDIC_GAIN;
        phi_rot_next.y    = '0;
        phi_rot_next.z    = {2'b00, phi_prod[61:31]};
        phi_rot_next.quad = aphi[31:30];
        th_rot_next.x     = CORDIC_GAIN;
        th_rot_next.y     = '0;
        th_rot_next.z     = {2'b00, th_prod[61:31]};
        th_rot_next.quad  = ath[31:30];
        tex_next.tu       = side_reg[S_ANG-1].slice_ge ? 17'd65536
                                                       : {1'b0, th_div[DIV_STEPS].quo[31:16]};
        tex_next.tv       = side_reg[S_ANG-1].ring_ge ? 17'd65536
                                                      : {1'b0, phi_div[DIV_STEPS].quo[31:16]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            phi_rot_reg <= phi_rot_next;
            th_rot_reg  <= th_rot_next;
            tex_reg[0]  <= tex_next;
            for (int k = 1; k < N_TEX; k++) begin
                tex_reg[k] <= tex_reg[k-1];
            end
        end
    end

    assign phi_rot[0] = phi_rot_reg;
    assign th_rot[0]  = th_rot_reg;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        uvs_cordic_cell u_phi_rot (
            .aclk  (aclk),
            .en    (adv),
            .shamt (5'(k)),
            .angle (atan_q30(k)),
            .rot_i (phi_rot[k]),
            .rot_o (phi_rot[k+1])
        );
        uvs_cordic_cell u_th_rot (
            .aclk  (aclk),
            .en    (adv),
            .shamt (5'(k)),
            .angle (atan_q30(k)),
            .rot_i (th_rot[k]),
            .rot_o (th_rot[k+1])
        );
    end

    always_comb begin
        phi_trig_next = fold_quad(phi_rot[CORDIC_STAGES]);
        th_trig_next  = fold_quad(th_rot[CORDIC_STAGES]);
        nx_prod       = phi_trig_reg.s * th_trig_reg.c;
        nz_prod       = phi_trig_reg.s * th_trig_reg.s;
        nx_sum        = {nx_prod[31], nx_prod} + 33'sd8192;
        nz_sum        = {nz_prod[31], nz_prod} + 33'sd8192;
        nx_next       = sat_q14({nx_sum[32], nx_sum[32:14]});
        nz_next       = sat_q14({nz_sum[32], nz_sum[32:14]});
        rad_s         = {1'b0, sphere_radius_reg};
        px_prod       = rad_s * nx_reg;
        py_prod       = rad_s * ny_reg;
        pz_prod       = rad_s * nz_reg;
        px_sum        = {px_prod[32], px_prod} + 34'sd8192;
        py_sum        = {py_prod[32], py_prod} + 34'sd8192;
        pz_sum        = {pz_prod[32], pz_prod} + 34'sd8192;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            phi_trig_reg <= phi_trig_next;
            th_trig_reg  <= th_trig_next;
            nx_reg       <= nx_next;
            ny_reg       <= phi_trig_reg.c;
            nz_reg       <= nz_next;
            pos_x_reg    <= px_sum[30:14];
            pos_y_reg    <= py_sum[30:14];
            pos_z_reg    <= pz_sum[30:14];
            onx_reg      <= nx_reg;
            ony_reg      <= ny_reg;
            onz_reg      <= nz_reg;
        end
    end

    assign m_valid        = vld_reg[S_OUT];
    assign m_pos_x        = pos_x_reg;
    assign m_pos_y        = pos_y_reg;
    assign m_pos_z        = pos_z_reg;
    assign m_norm_x       = onx_reg;
    assign m_norm_y       = ony_reg;
    assign m_norm_z       = onz_reg;
    assign m_tex_u        = tex_reg[N_TEX-1].tu;
    assign m_tex_v        = tex_reg[N_TEX-1].tv;
    assign m_vertex_index = side_reg[S_OUT].vidx;
    assign m_lower_index  = side_reg[S_OUT].lidx;
    assign m_quad_valid   = side_reg[S_OUT].quad;
    assign m_beyond_grid  = side_reg[S_OUT].beyond;

    `UVS_ASSERT_RST(a_reset_empties, !aresetn |=> !m_valid, "pipeline not empty after reset")
    `UVS_ASSERT(a_accept_enters, s_valid && s_ready |=> vld_reg[0], "accepted beat lost")
    `UVS_ASSERT(a_flags_exclusive, m_valid |-> !(m_quad_valid && m_beyond_grid), "quad and off-grid both set")
    `UVS_ASSERT(a_zero_radius, m_valid && sphere_radius_reg == 16'd0 |-> m_pos_x == 17'sd0 && m_pos_y == 17'sd0 && m_pos_z == 17'sd0, "nonzero position at zero radius")
    `UVS_ASSERT(a_norm_range, m_valid |-> m_norm_y <= ONE_Q14 && m_norm_y >= -ONE_Q14, "normal out of range")

endmodule
